@@ src/assert_macros.svh @@
// assertion helpers included by the deque rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/deq_pkg.sv @@
package deq_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REVERSE    = 3'd4,
    ACT_STATUS     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  localparam int unsigned FIELD_WIDTH = 32;
  localparam int unsigned COUNT_FIELD_WIDTH = 5;

endpackage

@@ src/double_ended_queue_with_reverse.sv @@
// channel  | handshake                   | payload
// item     | item_valid / item_ready     | action, data_value
// result   | result_valid / result_ready | front_value, back_value, entry_count,
//          |                             | is_empty, error_code
// an item passes through three steps: update and ring write, ring read at both ends, result load
// the ring memory has registered read ports, so the ring read is a step of its own
// a waiting result does not block the next item; only the result load waits for the sink
// synchronous active-high reset empties the queue; ring contents are not cleared
`include "assert_macros.svh"

module double_ended_queue_with_reverse #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  action,
  input  logic [31:0] data_value,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] front_value,
  output logic [31:0] back_value,
  output logic [4:0]  entry_count,
  output logic        is_empty,
  output logic [1:0]  error_code
);
  import deq_pkg::*;

  localparam int unsigned SW   = (DATA_WIDTH < FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SUMW = CW + 1;

  logic [SW-1:0] entry_store [DEPTH];

  state_t        state, state_next;
  logic [AW-1:0] first_slot, first_slot_next;
  logic [CW-1:0] stored_count, stored_count_next;
  logic          order_reversed, order_reversed_next;
  err_t          pend_err, pend_err_next;

  logic [SW-1:0] rd_start, rd_end;
  logic [AW-1:0] tail_slot, last_slot, dec_slot, inc_slot;
  logic [SUMW-1:0] tail_sum;
  logic          accept, load, full, empty, at_start, mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] word;
  logic [31:0]   start_word, end_word;

  assign accept     = item_valid && item_ready;
  assign item_ready = (state == ST_IDLE);
  assign load       = (state == ST_LOAD) && (!result_valid || result_ready);
  assign word       = data_value[SW-1:0];
  assign full       = (stored_count == CW'(DEPTH));
  assign empty      = (stored_count == '0);

  // ring arithmetic around the current pointers
  always_comb begin
    tail_sum = SUMW'(first_slot) + SUMW'(stored_count);
    if (tail_sum >= SUMW'(DEPTH)) begin
      tail_sum = tail_sum - SUMW'(DEPTH);
    end
    tail_slot = tail_sum[AW-1:0];
    last_slot = (tail_slot == '0) ? AW'(DEPTH - 1) : tail_slot - AW'(1);
    dec_slot  = (first_slot == '0) ? AW'(DEPTH - 1) : first_slot - AW'(1);
    inc_slot  = (first_slot == AW'(DEPTH - 1)) ? '0 : first_slot + AW'(1);
  end

  always_comb begin
    first_slot_next     = first_slot;
    stored_count_next   = stored_count;
    order_reversed_next = order_reversed;
    pend_err_next       = pend_err;
    state_next          = state;
    mem_we              = 1'b0;
    mem_waddr           = tail_slot;
    at_start            = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next    = ST_READ;
          pend_err_next = ERR_NONE;
          unique case (action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              at_start = (action == ACT_PUSH_FRONT) != order_reversed;
              if (full) begin
                pend_err_next = ERR_FULL;
              end else begin
                mem_we            = 1'b1;
                stored_count_next = stored_count + CW'(1);
                if (at_start) begin
                  first_slot_next = dec_slot;
                  mem_waddr       = dec_slot;
                end
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              at_start = (action == ACT_POP_FRONT) != order_reversed;
              if (empty) begin
                pend_err_next = ERR_EMPTY;
              end else begin
                stored_count_next = stored_count - CW'(1);
                if (at_start) begin
                  first_slot_next = inc_slot;
                end
              end
            end
            ACT_REVERSE: begin
              if (empty) begin
                pend_err_next = ERR_EMPTY;
              end else begin
                order_reversed_next = !order_reversed;
              end
            end
            default: begin
              // status only, also the unused codes
            end
          endcase
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      first_slot     <= '0;
      stored_count   <= '0;
      order_reversed <= 1'b0;
      pend_err       <= ERR_NONE;
      result_valid   <= 1'b0;
    end else begin
      state          <= state_next;
      first_slot     <= first_slot_next;
      stored_count   <= stored_count_next;
      order_reversed <= order_reversed_next;
      pend_err       <= pend_err_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_store[mem_waddr] <= word;
    end
    if (state == ST_READ) begin
      rd_start <= entry_store[first_slot];
      rd_end   <= entry_store[last_slot];
    end
  end

  always_comb begin
    start_word         = '0;
    end_word           = '0;
    start_word[SW-1:0] = rd_start;
    end_word[SW-1:0]   = rd_end;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (empty) begin
        front_value <= '0;
        back_value  <= '0;
      end else begin
        front_value <= order_reversed ? end_word : start_word;
        back_value  <= order_reversed ? start_word : end_word;
      end
      entry_count <= COUNT_FIELD_WIDTH'(stored_count);
      is_empty    <= empty;
      error_code  <= pend_err;
    end
  end

  `ASSERT_IMPLIES(a_count_bound, 1'b1, stored_count <= CW'(DEPTH), "count above depth")
  `ASSERT_IMPLIES(a_first_bound, 1'b1, first_slot <= AW'(DEPTH - 1), "first slot out of ring")
  `ASSERT_NEXT(a_accept_reads, accept, state == ST_READ, "accepted beat skipped ring read")
  `ASSERT_NEXT(a_load_shows, load, result_valid, "loaded result not presented")
  `ASSERT_IMPLIES(a_empty_zero, result_valid && is_empty,
                  front_value == '0 && back_value == '0 && entry_count == '0,
                  "empty result carries data")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 820;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_WAIT     = 6;

  typedef struct packed {
    logic [31:0] front;
    logic [31:0] back;
    logic [4:0]  count;
    logic        empty;
    err_t        err;
  } deq_status_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  logic [2:0]  action       = ACT_STATUS;
  logic [31:0] data_value   = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] front_value;
  logic [31:0] back_value;
  logic [4:0]  entry_count;
  logic        is_empty;
  logic [1:0]  error_code;

  // predictor state
  logic [31:0] ring_word [DEPTH];
  logic [3:0]  head_slot = '0;
  logic [4:0]  fill      = '0;
  logic        flipped   = 1'b0;

  deq_status_t due_status [$];

  bit          src_steady  = 1'b0;
  bit          sink_steady = 1'b0;
  int unsigned failures    = 0;
  int unsigned cycles      = 0;
  int unsigned items_seen  = 0;
  int unsigned beats_seen  = 0;
  int unsigned full_pushes = 0;
  int unsigned empty_ops   = 0;
  int unsigned flips_done  = 0;
  int unsigned times_full  = 0;

  double_ended_queue_with_reverse dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .data_value   (data_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .front_value  (front_value),
    .back_value   (back_value),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .error_code   (error_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, due_status.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // applies one request to the predicted deque and returns the status it leaves
  function automatic deq_status_t deque_step(logic [2:0] act, logic [31:0] word);
    deq_status_t r;
    logic        to_head;
    logic [3:0]  tail;
    r.err = ERR_NONE;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        // the head end of the ring is the front only in normal order
        to_head = (act == ACT_PUSH_FRONT) ^ flipped;
        if (fill == DEPTH) begin
          r.err = ERR_FULL;
        end else if (to_head) begin
          head_slot = head_slot - 4'd1;
          ring_word[head_slot] = word;
          fill = fill + 5'd1;
        end else begin
          ring_word[4'(head_slot + fill[3:0])] = word;
          fill = fill + 5'd1;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        to_head = (act == ACT_POP_FRONT) ^ flipped;
        if (fill == 0) begin
          r.err = ERR_EMPTY;
        end else begin
          if (to_head) head_slot = head_slot + 4'd1;
          fill = fill - 5'd1;
        end
      end
      ACT_REVERSE: begin
        if (fill == 0) r.err = ERR_EMPTY;
        else flipped = !flipped;
      end
      default: ;
    endcase
    tail = head_slot + fill[3:0] - 4'd1;
    r.front = '0;
    r.back  = '0;
    if (fill != 0) begin
      r.front = flipped ? ring_word[tail] : ring_word[head_slot];
      r.back  = flipped ? ring_word[head_slot] : ring_word[tail];
    end
    r.count = fill;
    r.empty = (fill == 0);
    return r;
  endfunction

  // predict on each accepted request beat, then check each accepted response beat
  always @(posedge clk) begin : scoreboard
    deq_status_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        want = deque_step(action, data_value);
        due_status.push_back(want);
        items_seen++;
        if (want.err == ERR_FULL) full_pushes++;
        if (want.err == ERR_EMPTY) empty_ops++;
        if (action == ACT_REVERSE && want.err == ERR_NONE) flips_done++;
        if (want.count == DEPTH && want.err == ERR_NONE &&
            (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK)) times_full++;
      end
      if (result_valid && result_ready) begin
        beats_seen++;
        if (due_status.size() == 0) begin
          failures++;
          $display("%0t: response with none outstanding, expected nothing got count %0d",
                   $time, entry_count);
        end else begin
          want = due_status.pop_front();
          if (front_value !== want.front) begin
            failures++;
            $display("%0t: front_value expected %h got %h", $time, want.front, front_value);
          end
          if (back_value !== want.back) begin
            failures++;
            $display("%0t: back_value expected %h got %h", $time, want.back, back_value);
          end
          if (entry_count !== want.count) begin
            failures++;
            $display("%0t: entry_count expected %0d got %0d", $time, want.count, entry_count);
          end
          if (is_empty !== want.empty) begin
            failures++;
            $display("%0t: is_empty expected %b got %b", $time, want.empty, is_empty);
          end
          if (error_code !== want.err) begin
            failures++;
            $display("%0t: error_code expected %0d got %0d", $time, want.err, error_code);
          end
        end
      end
    end
  end

  // response sink: random stall before each beat unless held steady
  initial begin : sink
    int unsigned hold;
    forever begin
      hold = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold != 0) begin
        result_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!(result_valid && !rst)) @(posedge clk);
    end
  end

  task automatic send_item(logic [2:0] act, logic [31:0] word);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    data_value <= word;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_status.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_item(ACT_POP_FRONT, $urandom);
    send_item(ACT_POP_BACK, $urandom);
    send_item(ACT_REVERSE, $urandom);
    send_item(ACT_STATUS, $urandom);
    // unused action codes behave as status
    send_item(3'd6, $urandom);
    send_item(3'd7, $urandom);
  endtask

  task automatic test_end_order();
    send_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(ACT_PUSH_BACK, 32'h0000_0000);
    send_item(ACT_PUSH_FRONT, 32'h8000_0000);
    send_item(ACT_REVERSE, $urandom);
    send_item(ACT_POP_FRONT, $urandom);
    send_item(ACT_PUSH_FRONT, 32'h0000_0001);
    send_item(ACT_POP_BACK, $urandom);
    send_item(ACT_REVERSE, $urandom);
  endtask

  task automatic test_full_queue();
    int i;
    // fill while reversed so both ring ends wrap
    send_item(ACT_REVERSE, $urandom);
    for (i = 0; fill + due_status.size() < DEPTH + 8 && i < DEPTH; i++) begin
      send_item(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, 32'h5A5A_0000 | i);
    end
    wait_drained();
    while (fill < DEPTH) send_item(ACT_PUSH_BACK, $urandom);
    send_item(ACT_PUSH_FRONT, $urandom);
    send_item(ACT_PUSH_BACK, $urandom);
    send_item(ACT_REVERSE, $urandom);
  endtask

  function automatic logic [2:0] pick_action(int unsigned mood);
    int unsigned roll;
    int unsigned push_cut;
    int unsigned pop_cut;
    roll = $urandom_range(0, 99);
    case (mood)
      0:       begin push_cut = 70; pop_cut = 85; end
      1:       begin push_cut = 20; pop_cut = 75; end
      default: begin push_cut = 42; pop_cut = 84; end
    endcase
    if (roll < push_cut) return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    if (roll < pop_cut) return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
    if (roll < pop_cut + 8) return ACT_REVERSE;
    if (roll < pop_cut + 12) return ACT_STATUS;
    return 3'(6 + $urandom_range(0, 1));
  endfunction

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase;
    int unsigned span;
    int unsigned mood;
    int unsigned k;
    logic [31:0] word;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      span        = $urandom_range(20, 60);
      mood        = $urandom_range(0, 2);
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      for (k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0:       word = 32'h0000_0000;
          1:       word = 32'hFFFF_FFFF;
          default: word = $urandom;
        endcase
        send_item(pick_action(mood), word);
        sent++;
      end
      phase++;
      if (phase % 5 == 0) wait_drained();
    end
  endtask

  initial begin : main
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_end_order();
    test_full_queue();
    wait_drained();
    test_random_traffic();
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (due_status.size() != 0) begin
      failures++;
      $display("%0t: %0d responses never arrived", $time, due_status.size());
    end
    $display("covered %0d requests and %0d responses, %0d mismatches",
             items_seen, beats_seen, failures);
    $display("reached full %0d times, %0d overflow pushes, %0d empty pops/reverses, %0d flips",
             times_full, full_pushes, empty_ops, flips_done);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/deq_pkg.sv
src/double_ended_queue_with_reverse.sv
tb/tb.sv
